### rtl/core/ssbs_pkg.sv
// ----------------------------------------------------------------------------
// ssbs_pkg: shared types and constants of the SPI peripheral byte sampler
// Pin position type, configuration register codes, and the sampler phase
// encoding used by the register bank and the top level.
// ----------------------------------------------------------------------------
package ssbs_pkg;

  // Bit position inside the 32-bit pin level word
  localparam int PinWordW = 32;
  localparam int PinPosW  = 5;
  typedef logic [PinPosW-1:0] pin_pos_t;

  // Configuration port
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CE    = 2'd0,
    CFG_CLOCK = 2'd1,
    CFG_DATA  = 2'd2
  } cfg_reg_t;

  localparam pin_pos_t CeBitReset    = 5'd0;
  localparam pin_pos_t ClockBitReset = 5'd1;
  localparam pin_pos_t DataBitReset  = 5'd2;

  // Pin roles handed from the register bank to the sampler
  typedef struct packed {
    pin_pos_t ce;
    pin_pos_t clock;
    pin_pos_t data;
  } pin_map_t;

  // Byte assembly
  localparam logic [3:0] ByteBits = 4'd8;
  localparam logic [2:0] TopBit   = 3'd7;

  // Sampler phase, one-hot
  typedef enum logic [2:0] {
    PH_SYNC      = 3'b001,
    PH_WAIT_LOW  = 3'b010,
    PH_WAIT_HIGH = 3'b100
  } phase_t;

endpackage

### rtl/core/ssbs_cfg.sv
// ----------------------------------------------------------------------------
// ssbs_cfg: pin role register bank
// Holds the bit positions of chip enable, serial clock and data-in; writes
// to an index past the last register are dropped.
// ----------------------------------------------------------------------------
module ssbs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  ssbs_pkg::pin_pos_t            cfg_data,
  output ssbs_pkg::pin_map_t            pin_map
);
  import ssbs_pkg::*;

  pin_map_t regs;

  // Update the addressed register on a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ce    <= CeBitReset;
      regs.clock <= ClockBitReset;
      regs.data  <= DataBitReset;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CE:    regs.ce    <= cfg_data;
        CFG_CLOCK: regs.clock <= cfg_data;
        CFG_DATA:  regs.data  <= cfg_data;
        default:   regs       <= regs;
      endcase
    end
  end

  assign pin_map = regs;

endmodule

### rtl/core/spi_slave_byte_sampler.sv
// ----------------------------------------------------------------------------
// spi_slave_byte_sampler: SPI mode 0 peripheral receiver on sampled pins
// Assembles MSB-first bytes from a stream of 32-bit GPIO level samples.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: one pin_levels word per transfer (sample_valid,
//   sample_stall). Byte channel: one received_byte per completed byte
//   (byte_valid, byte_stall). Config channel: cfg_index selects chip enable
//   (0), clock (1) or data (2) position, cfg_data gives the bit position;
//   cfg_ready is always high. Write configuration only while idle.
//   Throughput: one sample per cycle while byte_stall does not hold a
//   waiting byte. A sample goes into an input register, then the step logic
//   updates the phase, bit count and shift byte and loads the byte register,
//   so a byte is offered from the byte register once the step has run on
//   the sample with its eighth rising clock edge.
//   Stall: while byte_stall holds a waiting byte, the input register stops
//   and sample_stall rises once it is occupied; one sample is buffered.
//   Reset: synchronous; clears both stages, phase to sync, bit count and
//   shift byte to zero, and the pin positions to 0, 1 and 2.
// ----------------------------------------------------------------------------
module spi_slave_byte_sampler (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [ssbs_pkg::PinWordW-1:0] pin_levels,
  // byte channel
  output logic                          byte_valid,
  input  logic                          byte_stall,
  output logic [7:0]                    received_byte,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  ssbs_pkg::pin_pos_t            cfg_data
);
  import ssbs_pkg::*;

  pin_map_t              pin_map;
  logic                  s1_valid;
  logic [PinWordW-1:0]   s1_levels;
  logic                  advance;
  logic                  do_step;
  logic                  sample_take;

  phase_t                phase;
  phase_t                phase_next;
  logic [3:0]            bit_count;
  logic [3:0]            bit_count_next;
  logic [7:0]            shift_byte;
  logic [7:0]            shift_byte_next;
  logic [7:0]            byte_done;
  logic                  emit;
  logic                  ce_pin;
  logic                  clock_pin;
  logic                  data_pin;

  assign cfg_ready = 1'b1;

  ssbs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pin_map   (pin_map)
  );

  // Handshake: the step runs whenever the byte register is free or draining
  assign advance      = !byte_valid || !byte_stall;
  assign do_step      = s1_valid && advance;
  assign sample_stall = s1_valid && !advance;
  assign sample_take  = sample_valid && !sample_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_take) begin
      s1_levels <= pin_levels;
    end
  end

  // Pick the pin roles out of the held sample
  assign ce_pin    = s1_levels[pin_map.ce];
  assign clock_pin = s1_levels[pin_map.clock];
  assign data_pin  = s1_levels[pin_map.data];

  // Step: shift in data on each rising edge; chip enable clears the byte
  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    emit            = 1'b0;
    byte_done       = shift_byte;
    if (ce_pin) begin
      bit_count_next  = '0;
      shift_byte_next = '0;
    end else begin
      case (phase)
        PH_WAIT_HIGH: begin
          if (clock_pin) begin
            shift_byte_next[TopBit - bit_count[2:0]] = data_pin;
            bit_count_next = bit_count + 4'd1;
            phase_next     = PH_WAIT_LOW;
          end
        end
        PH_WAIT_LOW: begin
          if (!clock_pin) begin
            phase_next = PH_WAIT_HIGH;
          end
        end
        default: begin
          phase_next = clock_pin ? PH_WAIT_LOW : PH_WAIT_HIGH;
        end
      endcase
      // Emit a full byte and return to sync
      if (bit_count_next == ByteBits) begin
        emit            = 1'b1;
        byte_done       = shift_byte_next;
        phase_next      = PH_SYNC;
        bit_count_next  = '0;
        shift_byte_next = '0;
      end
    end
  end

  // Sampler state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SYNC;
      bit_count  <= '0;
      shift_byte <= '0;
    end else if (do_step) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
    end
  end

  // Byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= do_step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && emit) begin
      received_byte <= byte_done;
    end
  end

endmodule

### rtl/core/ssbs_checker.sv
// ----------------------------------------------------------------------------
// ssbs_checker: port-level checks for the SPI peripheral byte sampler
// Watches the sample and byte channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ssbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       sample_stall,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] received_byte
);

  // Hold a stalled byte transfer
  a_byte_hold_valid: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid)
    else $error("byte_valid dropped while stalled");

  a_byte_hold_data: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> $stable(received_byte))
    else $error("received_byte changed while stalled");

  // Drop both stages on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !byte_valid && !sample_stall)
    else $error("pipeline not empty after reset");

  // An empty byte register never backs up the sample channel
  a_no_false_stall: assert property (@(posedge clk)
    !byte_valid |-> !sample_stall)
    else $error("sample stalled with free byte register");

endmodule

bind spi_slave_byte_sampler ssbs_checker u_ssbs_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_stall  (sample_stall),
  .byte_valid    (byte_valid),
  .byte_stall    (byte_stall),
  .received_byte (received_byte)
);

### verif/spi_slave_byte_sampler_tb.sv
// ----------------------------------------------------------------------------
// spi_slave_byte_sampler_tb: self-checking bench for the SPI byte sampler
// Drives GPIO level samples shaped as SPI mode 0 frames, plus noise and
// aborted frames, under several pin maps and idle/stall mixes. A local
// predictor of the sampler computes each expected byte, and a checker
// compares every byte transfer against the oldest expected one.
// ----------------------------------------------------------------------------
module spi_slave_byte_sampler_tb;
  import ssbs_pkg::*;

  localparam int                 ClkHalf     = 5;
  localparam int                 CycleLimit  = 200000;
  localparam int                 SettleTicks = 4;
  localparam int                 TailTicks   = 16;
  localparam logic [CfgIdxW-1:0] CfgUnused   = 2'd3;

  // DUT inputs, all known from time zero
  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                sample_valid = 1'b0;
  logic [PinWordW-1:0] pin_levels   = '0;
  logic                byte_stall   = 1'b0;
  logic                cfg_valid    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  pin_pos_t            cfg_data     = '0;

  logic       sample_stall;
  logic       byte_valid;
  logic [7:0] received_byte;
  logic       cfg_ready;

  // Predictor state and pin map
  pin_pos_t   map_ce    = CeBitReset;
  pin_pos_t   map_clock = ClockBitReset;
  pin_pos_t   map_data  = DataBitReset;
  phase_t     pred_phase = PH_SYNC;
  logic [3:0] pred_count = '0;
  logic [7:0] pred_acc   = '0;

  logic [7:0] pending_bytes[$];
  logic [7:0] want_byte;
  int         errors       = 0;
  int         cycles       = 0;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         samples_sent = 0;

  spi_slave_byte_sampler u_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .pin_levels    (pin_levels),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .received_byte (received_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** spi_slave_byte_sampler: FAILED **");
      $finish;
    end
  end

  // Stall the byte channel at random
  always @(posedge clk) begin
    byte_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check each byte transfer against the oldest expected byte
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %02h", $time, received_byte);
        errors++;
      end else begin
        want_byte = pending_bytes.pop_front();
        if (received_byte !== want_byte) begin
          $display("%0t: received_byte expected %02h actual %02h",
                   $time, want_byte, received_byte);
          errors++;
        end
      end
    end
  end

  // Advance the predicted sampler by one pin sample
  function automatic bit sample_to_byte(input logic [PinWordW-1:0] w,
                                        output logic [7:0] done_byte);
    logic sclk;
    sclk      = w[map_clock];
    done_byte = '0;
    if (w[map_ce]) begin
      pred_count = '0;
      pred_acc   = '0;
      return 1'b0;
    end
    case (pred_phase)
      PH_WAIT_HIGH: begin
        if (sclk) begin
          pred_acc   = pred_acc | (8'(w[map_data]) << (TopBit - pred_count[2:0]));
          pred_count = pred_count + 4'd1;
          pred_phase = PH_WAIT_LOW;
        end
      end
      PH_WAIT_LOW: begin
        if (!sclk) pred_phase = PH_WAIT_HIGH;
      end
      default: begin
        pred_phase = sclk ? PH_WAIT_LOW : PH_WAIT_HIGH;
      end
    endcase
    if (pred_count == ByteBits) begin
      done_byte  = pred_acc;
      pred_phase = PH_SYNC;
      pred_count = '0;
      pred_acc   = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Send one sample, idling at random first; hold the payload while stalled
  task automatic send_sample(input logic [PinWordW-1:0] w);
    logic [7:0] b;
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    pin_levels   <= w;
    do @(posedge clk); while (sample_stall);
    samples_sent++;
    if (sample_to_byte(w, b)) pending_bytes.push_back(b);
  endtask

  // Random background word with the three roles forced
  function automatic logic [PinWordW-1:0] pin_word(input logic ce, input logic sclk,
                                                   input logic din);
    logic [PinWordW-1:0] w;
    w            = $urandom;
    w[map_data]  = din;
    w[map_clock] = sclk;
    w[map_ce]    = ce;
    return w;
  endfunction

  // Drop valid and wait until no byte is owed
  task automatic drain_bytes();
    sample_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one register once the sampler has gone quiet
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input pin_pos_t val);
    drain_bytes();
    repeat (SettleTicks) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CE:    map_ce    = val;
      CFG_CLOCK: map_clock = val;
      CFG_DATA:  map_data  = val;
      default: ;
    endcase
  endtask

  task automatic load_pin_map(input pin_pos_t ce, input pin_pos_t sclk, input pin_pos_t din);
    write_reg(CFG_CE, ce);
    write_reg(CFG_CLOCK, sclk);
    write_reg(CFG_DATA, din);
  endtask

  // Send a mode 0 frame, MSB first; a short frame ends with chip enable high
  task automatic send_frame(input logic [7:0] val, input int nbits, input bit start_high,
                            input int max_hold);
    int lead;
    lead = $urandom_range(max_hold - 1);
    repeat (lead) send_sample(pin_word(1'b1, 1'($urandom), 1'($urandom)));
    if (start_high) send_sample(pin_word(1'b0, 1'b1, 1'($urandom)));
    for (int i = 0; i < nbits; i++) begin
      repeat ($urandom_range(max_hold, 1)) send_sample(pin_word(1'b0, 1'b0, 1'($urandom)));
      repeat ($urandom_range(max_hold, 1)) send_sample(pin_word(1'b0, 1'b1, val[7 - i]));
    end
    if (nbits < 8) send_sample(pin_word(1'b1, 1'($urandom), 1'($urandom)));
  endtask

  // All-ones word with chip enable high, then a full-ones byte from clock high
  task automatic test_default_map();
    send_sample('1);
    send_frame(8'hFF, 8, 1'b1, 1);
  endtask

  // Abort a byte with chip enable high; the chosen edge survives the abort
  task automatic test_chip_enable_abort();
    send_sample('0);
    send_sample(pin_word(1'b0, 1'b1, 1'b1));
    send_sample(pin_word(1'b0, 1'b0, 1'b0));
    send_sample(pin_word(1'b0, 1'b1, 1'b0));
    send_sample(pin_word(1'b1, 1'b1, 1'b1));
    send_sample(pin_word(1'b0, 1'b1, 1'b1));
    send_sample(pin_word(1'b0, 1'b0, 1'b1));
    send_sample(pin_word(1'b1, 1'b0, 1'b0));
  endtask

  // Write the unused index; the map must not move
  task automatic test_unused_register();
    write_reg(CfgUnused, pin_pos_t'($urandom));
    send_frame(8'h00, 8, 1'b0, 1);
  endtask

  // Mostly well-formed frames, some broken ones and noise bursts
  task automatic test_random_traffic(input int n, input bit with_pause);
    int first;
    int roll;
    bit paused;
    first  = samples_sent;
    paused = 1'b0;
    while (samples_sent - first < n) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        send_frame(8'($urandom), 8, 1'($urandom), 3);
      end else if (roll < 87) begin
        send_frame(8'($urandom), $urandom_range(7, 1), 1'($urandom), 2);
      end else begin
        repeat ($urandom_range(4, 1)) send_sample($urandom);
      end
      if (with_pause && !paused && samples_sent - first >= n / 2) begin
        drain_bytes();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_distinct_random_map();
    pin_pos_t a;
    pin_pos_t b;
    pin_pos_t c;
    a = pin_pos_t'($urandom);
    do b = pin_pos_t'($urandom); while (b == a);
    do c = pin_pos_t'($urandom); while (c == a || c == b);
    load_pin_map(a, b, c);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset map, no idling
    test_default_map();
    test_chip_enable_abort();
    test_unused_register();

    // Extreme positions, sender idles lightly, receiver stalls heavily
    idle_pct  = 21;
    stall_pct = 77;
    load_pin_map(5'd31, 5'd0, 5'd15);
    test_random_traffic(300, 1'b0);

    // Other extremes, roles swapped, with one full drain pause
    idle_pct  = 77;
    stall_pct = 21;
    load_pin_map(5'd16, 5'd31, 5'd0);
    test_random_traffic(300, 1'b1);

    // All roles on one pin
    load_pin_map(5'd9, 5'd9, 5'd9);
    test_random_traffic(60, 1'b0);

    // Random distinct map, no idling
    idle_pct  = 0;
    stall_pct = 0;
    test_distinct_random_map();
    test_random_traffic(300, 1'b0);

    // Drain and let the pipeline settle
    drain_bytes();
    repeat (TailTicks) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** spi_slave_byte_sampler: PASSED **");
    end else begin
      $display("** spi_slave_byte_sampler: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ssbs_pkg.sv
rtl/core/ssbs_cfg.sv
rtl/core/spi_slave_byte_sampler.sv
rtl/core/ssbs_checker.sv
verif/spi_slave_byte_sampler_tb.sv
